FILE: sv/bam_pkg.sv
// Shared constants, command codes and control structs for the BFS adjacency-matrix block.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package bam_pkg;

    localparam int VERTEX_W         = 6;
    localparam int COUNT_W          = 7;
    localparam int MODE_W           = 2;
    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_EDGE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic                wr;
        logic                clr;
        logic [VERTEX_W-1:0] row;
        logic [VERTEX_W-1:0] col;
    } bam_adj_cmd_t;

    typedef struct packed {
        logic                en;
        logic [VERTEX_W-1:0] addr;
    } bam_rd_req_t;

    typedef struct packed {
        logic                go;
        logic [VERTEX_W-1:0] src;
        logic [COUNT_W-1:0]  count;
    } bam_start_t;

endpackage

`default_nettype wire

FILE: sv/bam_if.sv
// Valid/ready channel interfaces: command items, result items and the vertex count write.
// Depends on bam_pkg for field widths.
`default_nettype none

interface bam_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [bam_pkg::MODE_W-1:0]    mode;
    logic [bam_pkg::VERTEX_W-1:0]  vertex_a;
    logic [bam_pkg::VERTEX_W-1:0]  vertex_b;

    modport source (output valid, output mode, output vertex_a, output vertex_b, input ready);
    modport sink   (input valid, input mode, input vertex_a, input vertex_b, output ready);
endinterface

interface bam_res_if;
    logic                          valid;
    logic                          ready;
    logic [bam_pkg::VERTEX_W-1:0]  vertex;
    logic                          reached;
    logic [bam_pkg::VERTEX_W-1:0]  distance;
    logic [bam_pkg::VERTEX_W-1:0]  predecessor;
    logic                          last;

    modport source (output valid, output vertex, output reached, output distance,
                    output predecessor, output last, input ready);
    modport sink   (input valid, input vertex, input reached, input distance,
                    input predecessor, input last, output ready);
endinterface

interface bam_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bam_pkg::COUNT_W-1:0]   vertex_count;

    modport source (output valid, output vertex_count, input ready);
    modport sink   (input valid, input vertex_count, output ready);
endinterface

`default_nettype wire

FILE: sv/bfs_adjacency_matrix.sv
// Breadth-first search over a bit adjacency matrix of up to MAX_VERTICES vertices.
//
// Channels: cmd takes items {mode, vertex_a, vertex_b}; res gives one item per vertex
// in use after a search, in ascending vertex order, with last set on the final one;
// cfg writes vertex_count (0 acts as 1, above MAX_VERTICES acts as MAX_VERTICES).
// Add-edge makes one matrix write per direction.
// Mode 3 and edges with an endpoint at or above MAX_VERTICES are dropped.
// A search reads one matrix row per dequeued vertex and tests one neighbor per
// cycle against that row; the row scan sets the rate. Results then follow, each
// held until res is ready.
// cmd.ready stays low while an item is in progress; one item is worked at a time.
// Reset: matrix reads as its diagonal (per-row valid bits clear at once, no sweep),
// vertex_count returns to 64, the block is idle and ready.
// A stalled receiver holds the current result in the output register and the
// sequencer waits; nothing is lost or repeated.
// Depends on bam_pkg, bam_if, bam_adj_store, bam_search.
`default_nettype none

module bfs_adjacency_matrix #(
    parameter int MAX_VERTICES = bam_pkg::MAX_VERTICES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bam_cmd_if.sink     cmd,
    bam_res_if.source   res,
    bam_cfg_if.sink     cfg
);
    import bam_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_VERTICES);

    logic [COUNT_W-1:0]  vertex_count_reg;
    logic                pend_reg, pend_next;
    logic [VERTEX_W-1:0] pend_row_reg, pend_col_reg;
    logic [COUNT_W-1:0]  active_count;
    logic                cmd_fire;
    logic                edge_ok;
    logic                busy;
    bam_adj_cmd_t        adj_cmd;
    bam_rd_req_t         adj_rd;
    bam_start_t          start;
    logic [MAX_VERTICES-1:0] adj_row;

    assign cfg.ready = 1'b1;
    assign cmd.ready = !busy && !pend_reg;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign edge_ok = (COUNT_W'(cmd.vertex_a) < MAX_COUNT) && (COUNT_W'(cmd.vertex_b) < MAX_COUNT);

    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            active_count = COUNT_W'(1);
        end
        else if (vertex_count_reg > MAX_COUNT)
        begin
            active_count = MAX_COUNT;
        end
        else
        begin
            active_count = vertex_count_reg;
        end
    end

    always_comb
    begin
        adj_cmd.wr  = 1'b0;
        adj_cmd.clr = 1'b0;
        adj_cmd.row = cmd.vertex_a;
        adj_cmd.col = cmd.vertex_b;
        start.go    = 1'b0;
        start.src   = cmd.vertex_a;
        start.count = active_count;
        pend_next   = 1'b0;

        if (pend_reg)
        begin
            adj_cmd.wr  = 1'b1;
            adj_cmd.row = pend_row_reg;
            adj_cmd.col = pend_col_reg;
        end
        else if (cmd_fire)
        begin
            unique case (cmd.mode)
                MODE_EDGE:
                begin
                    adj_cmd.wr = edge_ok;
                    pend_next  = edge_ok;
                end
                MODE_SEARCH:
                begin
                    start.go = 1'b1;
                end
                MODE_CLEAR:
                begin
                    adj_cmd.clr = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
            pend_reg         <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cfg.valid && cfg.ready)
            begin
                vertex_count_reg <= cfg.vertex_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_next)
        begin
            pend_row_reg <= cmd.vertex_b;
            pend_col_reg <= cmd.vertex_a;
        end
    end

    bam_adj_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_adj_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (adj_cmd),
        .rd    (adj_rd),
        .row   (adj_row)
    );

    bam_search #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .adj_rd  (adj_rd),
        .adj_row (adj_row),
        .res     (res)
    );

endmodule

`default_nettype wire

FILE: sv/bam_adj_store.sv
// Adjacency matrix: one row per vertex in a memory, with a per-row valid bit that
// makes a row read as its diagonal until first written. Depends on bam_pkg.
`default_nettype none

module bam_adj_store #(
    parameter int MAX_VERTICES = bam_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bam_pkg::bam_adj_cmd_t     wr,
    input  wire bam_pkg::bam_rd_req_t      rd,
    output logic [MAX_VERTICES-1:0]        row
);
    import bam_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);

    logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] rdata_reg;
    logic                    rd_valid_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic [AW-1:0]           wr_row;
    logic [AW-1:0]           wr_col;
    logic [AW-1:0]           rd_addr;

    assign wr_row  = wr.row[AW-1:0];
    assign wr_col  = wr.col[AW-1:0];
    assign rd_addr = rd.addr[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr.clr)
        begin
            row_valid_reg <= '0;
        end
        else if (wr.wr)
        begin
            row_valid_reg[wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr)
        begin
            if (row_valid_reg[wr_row])
            begin
                mem[wr_row][wr_col] <= 1'b1;
            end
            else
            begin
                mem[wr_row] <= (ROW_ONE << wr_row) | (ROW_ONE << wr_col);
            end
        end
        if (rd.en)
        begin
            rdata_reg    <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
            rd_addr_reg  <= rd_addr;
        end
    end

    assign row = rd_valid_reg ? rdata_reg : (ROW_ONE << rd_addr_reg);

endmodule

`default_nettype wire

FILE: sv/bam_search.sv
// Search sequencer: vertex queue, visited bits, distance and predecessor memories,
// one-neighbor-per-cycle row scan and the result register. Depends on bam_pkg, bam_if.
`default_nettype none

module bam_search #(
    parameter int MAX_VERTICES = bam_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bam_pkg::bam_start_t       start,
    output logic                           busy,
    output bam_pkg::bam_rd_req_t           adj_rd,
    input  wire logic [MAX_VERTICES-1:0]   adj_row,
    bam_res_if.source                      res
);
    import bam_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DEQ       = 7'b0000010,
        S_QRD       = 7'b0000100,
        S_SCAN      = 7'b0001000,
        S_EMIT_RD   = 7'b0010000,
        S_EMIT_LD   = 7'b0100000,
        S_EMIT_HOLD = 7'b1000000
    } bam_state_t;

    bam_state_t              state_reg, state_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           head_reg, head_next;
    logic [CW-1:0]           tail_reg, tail_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_load;

    logic [VERTEX_W-1:0]     out_vertex_reg;
    logic                    out_reached_reg;
    logic [VERTEX_W-1:0]     out_distance_reg;
    logic [VERTEX_W-1:0]     out_pred_reg;
    logic                    out_last_reg;

    logic [AW-1:0] dist_mem  [MAX_VERTICES];
    logic [AW-1:0] pred_mem  [MAX_VERTICES];
    logic [AW-1:0] queue_mem [MAX_VERTICES];

    logic          dist_we, pred_we, q_we;
    logic [AW-1:0] dist_waddr, pred_waddr, q_waddr;
    logic [AW-1:0] dist_wdata, pred_wdata, q_wdata;
    logic          dist_re, pred_re, q_re;
    logic [AW-1:0] dist_raddr;
    logic [AW-1:0] dist_rdata_reg, pred_rdata_reg, q_rdata_reg;

    logic          idx_last;
    logic          src_in_range;
    logic          hit;

    assign idx_last     = (CW'(idx_reg) + CW'(1)) == n_reg;
    assign src_in_range = COUNT_W'(start.src) < start.count;
    assign hit          = visited_reg[idx_reg];
    assign busy         = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        n_next         = n_reg;
        visited_next   = visited_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        dist_we        = 1'b0;
        dist_waddr     = idx_reg;
        dist_wdata     = dist_rdata_reg + AW'(1);
        pred_we        = 1'b0;
        pred_waddr     = idx_reg;
        pred_wdata     = q_rdata_reg;
        q_we           = 1'b0;
        q_waddr        = tail_reg[AW-1:0];
        q_wdata        = idx_reg;
        dist_re        = 1'b0;
        dist_raddr     = idx_reg;
        pred_re        = 1'b0;
        q_re           = 1'b0;
        adj_rd.en      = 1'b0;
        adj_rd.addr    = VERTEX_W'(q_rdata_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start.go)
                begin
                    n_next    = start.count[CW-1:0];
                    idx_next  = '0;
                    head_next = '0;
                    if (src_in_range)
                    begin
                        visited_next = ROW_ONE << start.src[AW-1:0];
                        dist_we      = 1'b1;
                        dist_waddr   = start.src[AW-1:0];
                        dist_wdata   = '0;
                        q_we         = 1'b1;
                        q_waddr      = '0;
                        q_wdata      = start.src[AW-1:0];
                        tail_next    = CW'(1);
                        state_next   = S_DEQ;
                    end
                    else
                    begin
                        visited_next = '0;
                        tail_next    = '0;
                        state_next   = S_EMIT_RD;
                    end
                end
            end
            S_DEQ:
            begin
                idx_next = '0;
                if (head_reg == tail_reg)
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    q_re       = 1'b1;
                    head_next  = head_reg + CW'(1);
                    state_next = S_QRD;
                end
            end
            S_QRD:
            begin
                adj_rd.en  = 1'b1;
                dist_re    = 1'b1;
                dist_raddr = q_rdata_reg;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (adj_row[idx_reg] && !hit)
                begin
                    visited_next[idx_reg] = 1'b1;
                    dist_we   = 1'b1;
                    pred_we   = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + CW'(1);
                end
                if (idx_last)
                begin
                    state_next = S_DEQ;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_EMIT_RD:
            begin
                dist_re    = 1'b1;
                pred_re    = 1'b1;
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_EMIT_HOLD;
            end
            S_EMIT_HOLD:
            begin
                if (res.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            n_reg         <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            n_reg         <= n_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (dist_re)
        begin
            dist_rdata_reg <= dist_mem[dist_raddr];
        end
        if (pred_we)
        begin
            pred_mem[pred_waddr] <= pred_wdata;
        end
        if (pred_re)
        begin
            pred_rdata_reg <= pred_mem[idx_reg];
        end
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re)
        begin
            q_rdata_reg <= queue_mem[head_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_vertex_reg   <= VERTEX_W'(idx_reg);
            out_reached_reg  <= hit;
            out_distance_reg <= hit ? VERTEX_W'(dist_rdata_reg) : '0;
            out_pred_reg     <= (hit && dist_rdata_reg != '0) ? VERTEX_W'(pred_rdata_reg) : '0;
            out_last_reg     <= idx_last;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.vertex      = out_vertex_reg;
    assign res.reached     = out_reached_reg;
    assign res.distance    = out_distance_reg;
    assign res.predecessor = out_pred_reg;
    assign res.last        = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) head_reg <= tail_reg)
        else $error("queue head passed tail");

    assert property (@(posedge clk) disable iff (!rst_n) tail_reg <= n_reg || !busy)
        else $error("more vertices queued than in use");

    assert property (@(posedge clk) disable iff (!rst_n)
                     res.valid |-> state_reg == S_EMIT_HOLD)
        else $error("result shown outside emit hold");

    assert property (@(posedge clk) disable iff (!rst_n)
                     res.valid && res.ready && res.last |=> state_reg == S_IDLE)
        else $error("search did not finish after final result");

endmodule

`default_nettype wire
